@@ hdl/matrix_chain_cost_evaluator_core_defines.svh @@
// Assertion macros used by the checker file of the matrix chain cost evaluator.
`ifndef MATRIX_CHAIN_COST_EVALUATOR_CORE_DEFINES_SVH
`define MATRIX_CHAIN_COST_EVALUATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define MCCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during rst.
`define MCCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mcce_pkg.sv @@
// Types and constants of the matrix chain cost evaluator.
package mcce_pkg;

  localparam int STACK_DEPTH  = 64;
  localparam int DIM_WIDTH    = 64;
  localparam int LETTER_COUNT = 26;
  localparam int LETTER_W     = 5;
  localparam int IN_DIM_W     = 64;
  localparam int COST_W       = 64;
  localparam int HALF_W       = COST_W / 2;
  localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W        = $clog2(STACK_DEPTH);
  localparam int S_DATA_W     = ((LETTER_W + 2 * IN_DIM_W + 7) / 8) * 8;
  localparam int M_DATA_W     = COST_W;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_OPEN   = 2'd1,
    REQ_CLOSE  = 2'd2,
    REQ_LETTER = 2'd3
  } req_t;

endpackage

@@ hdl/matrix_chain_cost_evaluator_core.sv @@
// Matrix chain cost evaluator: stack machine with one shared 32x32 multiplier.
//
// Symbols of a fully parenthesised matrix product arrive one request at a time.
// Load requests fill a 26-entry size table (cleared at reset, unloaded letters
// are 0 by 0) and leave the block idle. An opening parenthesis goes through a
// finishing state, a letter through table read, push and finish. A closing
// parenthesis goes through accept, two registered stack reads, a size check,
// then rows*inner*cols built mod 2^64 from three 32x32 partial products per
// multiply on a single shared multiplier (two multiplies), then add and push,
// and a finish. The multiplier sequence sets the closing-parenthesis latency.
// A symbol marked tlast produces one result; if an earlier result is still
// held in the output register the block waits there until it is taken. An error
// (size mismatch, stack underflow or overflow) makes later symbols of the
// expression no-ops and the result reads cost 0, error 1. No clearing pass
// after reset.
module matrix_chain_cost_evaluator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [4:0] letter, [68:5] rows, [132:69] cols, [135:133] zero
  input  logic [mcce_pkg::S_DATA_W-1:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]                    s_axis_tuser,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [63:0] cost
  output logic [mcce_pkg::M_DATA_W-1:0] m_axis_tdata,
  // [0] error
  output logic                          m_axis_tuser
);
  import mcce_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PUSH  = 7'b0000010,
    S_POP_R = 7'b0000100,
    S_POP_L = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_MUL   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;

  // request fields
  logic                 accept;
  req_t                 kind;
  logic [LETTER_W-1:0]  letter;
  logic [DIM_WIDTH-1:0] in_rows, in_cols;
  logic                 letter_ok;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign kind      = req_t'(s_axis_tuser);
  assign letter    = s_axis_tdata[LETTER_W-1:0];
  assign in_rows   = DIM_WIDTH'(s_axis_tdata[LETTER_W +: IN_DIM_W]);
  assign in_cols   = DIM_WIDTH'(s_axis_tdata[LETTER_W + IN_DIM_W +: IN_DIM_W]);
  assign letter_ok = letter < LETTER_W'(LETTER_COUNT);

  assign s_axis_tready = (state == S_IDLE);

  // size table, valid bit per letter so reset reads as zero
  logic [DIM_WIDTH-1:0]    tbl_rows [LETTER_COUNT];
  logic [DIM_WIDTH-1:0]    tbl_cols [LETTER_COUNT];
  logic [LETTER_COUNT-1:0] tbl_vld;

  // operand stack: rows in upper half, cols in lower half
  logic [2*DIM_WIDTH-1:0] stack_mem [STACK_DEPTH];
  logic [2*DIM_WIDTH-1:0] stack_rd;
  logic [IDX_W-1:0]       rd_addr;
  logic [CNT_W-1:0]       stk_count;
  logic [CNT_W-1:0]       cnt_m1, cnt_m2;
  logic                   stk_full;

  assign cnt_m1   = stk_count - CNT_W'(1);
  assign cnt_m2   = stk_count - CNT_W'(2);
  assign stk_full = stk_count >= CNT_W'(STACK_DEPTH);
  assign rd_addr  = (state == S_POP_L) ? cnt_m2[IDX_W-1:0] : cnt_m1[IDX_W-1:0];

  // expression state
  logic [COST_W-1:0] cost_sum;
  logic              err_seen;
  logic              last_q;

  // result register loads when the last symbol finishes and the slot is free
  logic              out_load;

  assign out_load = (state == S_DONE) && last_q && (!m_axis_tvalid || m_axis_tready);

  // operands
  logic [DIM_WIDTH-1:0] push_rows, push_cols;
  logic [DIM_WIDTH-1:0] right_rows, right_cols;
  logic [DIM_WIDTH-1:0] left_rows, left_cols;

  assign left_rows = stack_rd[2*DIM_WIDTH-1:DIM_WIDTH];
  assign left_cols = stack_rd[DIM_WIDTH-1:0];

  // shared multiplier: step 0..2 issue partial products, steps 1..3 accumulate
  logic [1:0]          step;
  logic                pass;
  logic [COST_W-1:0]   mul_x, mul_y;
  logic [HALF_W-1:0]   mul_a, mul_b;
  logic [COST_W-1:0]   mul_p;
  logic                mul_sh;
  logic [COST_W-1:0]   acc, acc_next;
  logic [COST_W-1:0]   mul_term;

  always_comb begin
    unique case (step)
      2'd1:    begin mul_a = mul_x[HALF_W-1:0];      mul_b = mul_y[COST_W-1:HALF_W]; end
      2'd2:    begin mul_a = mul_x[COST_W-1:HALF_W]; mul_b = mul_y[HALF_W-1:0];      end
      default: begin mul_a = mul_x[HALF_W-1:0];      mul_b = mul_y[HALF_W-1:0];      end
    endcase
  end

  // cross terms land in the upper half only
  assign mul_term = mul_sh ? {mul_p[HALF_W-1:0], {HALF_W{1'b0}}} : mul_p;
  assign acc_next = acc + mul_term;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      stk_count     <= '0;
      cost_sum      <= '0;
      err_seen      <= 1'b0;
      tbl_vld       <= '0;
      step          <= '0;
      pass          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            priority if (kind == REQ_LOAD) begin
              if (letter_ok) begin
                tbl_vld[letter] <= 1'b1;
              end
            end else if (err_seen || kind == REQ_OPEN) begin
              state <= S_DONE;
            end else if (kind == REQ_LETTER) begin
              state <= S_PUSH;
            end else if (stk_count < CNT_W'(2)) begin
              err_seen <= 1'b1;   // underflow
              state    <= S_DONE;
            end else begin
              state <= S_POP_R;
            end
          end
        end
        S_POP_R: state <= S_POP_L;
        S_POP_L: state <= S_CHECK;
        S_CHECK: begin
          stk_count <= cnt_m2;
          if (left_cols != right_rows) begin
            err_seen <= 1'b1;     // inner sizes differ
            state    <= S_DONE;
          end else begin
            step  <= '0;
            pass  <= 1'b0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          step <= step + 2'd1;
          if (step == 2'd3) begin
            if (!pass) begin
              pass <= 1'b1;
            end else begin
              state <= S_PUSH;
            end
          end
        end
        S_PUSH: begin
          cost_sum <= cost_sum + acc;  // acc is zero for a letter
          if (stk_full) begin
            err_seen <= 1'b1;     // overflow
          end else begin
            stk_count <= stk_count + CNT_W'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!last_q) begin
            state <= S_IDLE;
          end else if (!m_axis_tvalid || m_axis_tready) begin
            stk_count     <= '0;
            cost_sum      <= '0;
            err_seen      <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    mul_p  <= COST_W'(mul_a) * COST_W'(mul_b);
    mul_sh <= (step != 2'd0);
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          last_q <= s_axis_tlast;
          acc    <= '0;
          if (letter_ok && tbl_vld[letter]) begin
            push_rows <= tbl_rows[letter];
            push_cols <= tbl_cols[letter];
          end else begin
            push_rows <= '0;
            push_cols <= '0;
          end
          if (kind == REQ_LOAD && letter_ok) begin
            tbl_rows[letter] <= in_rows;
            tbl_cols[letter] <= in_cols;
          end
        end
      end
      S_POP_L: begin
        right_rows <= stack_rd[2*DIM_WIDTH-1:DIM_WIDTH];
        right_cols <= stack_rd[DIM_WIDTH-1:0];
      end
      S_CHECK: begin
        push_rows <= left_rows;
        push_cols <= right_cols;
        mul_x     <= COST_W'(left_rows);
        mul_y     <= COST_W'(left_cols);
        acc       <= '0;
      end
      S_MUL: begin
        if (step == 2'd3 && !pass) begin
          // first product becomes the left operand of the second
          mul_x <= acc_next;
          mul_y <= COST_W'(right_cols);
          acc   <= '0;
        end else if (step != 2'd0) begin
          acc <= acc_next;
        end
      end
      S_DONE: begin
        if (last_q && (!m_axis_tvalid || m_axis_tready)) begin
          m_axis_tdata <= err_seen ? '0 : cost_sum;
          m_axis_tuser <= err_seen;
        end
      end
      default: ;
    endcase
  end

  // stack memory, registered read
  always_ff @(posedge clk) begin
    if (state == S_PUSH && !stk_full) begin
      stack_mem[stk_count[IDX_W-1:0]] <= {push_rows, push_cols};
    end
    stack_rd <= stack_mem[rd_addr];
  end

endmodule

@@ hdl/mcce_checker.sv @@
// Port-level checker for the matrix chain cost evaluator, bound to the core.
`include "matrix_chain_cost_evaluator_core_defines.svh"

module mcce_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [1:0]                    s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mcce_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);
  import mcce_pkg::*;

  // an error result never carries a cost
  `MCCE_ASSERT_IMP(a_err_zero_cost, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "error result with nonzero cost")

  // a held result does not change
  `MCCE_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // a load request does not hold the input
  `MCCE_ASSERT_NXT(a_load_single, s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_LOAD, s_axis_tready, "load request held the input")

  // any symbol request takes the block out of idle, so the input is held off after it
  `MCCE_ASSERT_NXT(a_symbol_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser != REQ_LOAD, !s_axis_tready, "symbol request did not block input")

endmodule

bind matrix_chain_cost_evaluator_core mcce_checker u_mcce_checker (.*);

@@ bench/matrix_chain_cost_evaluator_core_test.sv @@
// Self-checking testbench for the matrix chain cost evaluator core.
`timescale 1ns / 100ps

module matrix_chain_cost_evaluator_core_test;
  import mcce_pkg::*;

  // Letters used by the directed requests
  localparam int LTR_A   = 0;
  localparam int LTR_B   = 1;
  localparam int LTR_C   = 2;
  localparam int LTR_D   = 3;
  localparam int LTR_E   = 4;
  localparam int LTR_BAD = 31;  // beyond Z

  localparam logic [63:0] DIM_ONES = '1;

  typedef struct {
    req_t        kind;
    logic [4:0]  letter;
    logic [63:0] rows;
    logic [63:0] cols;
    logic        last;
  } symbol_t;

  typedef struct {
    logic [63:0] cost;
    logic        error;
  } chain_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = REQ_OPEN;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic                  m_axis_tuser;

  matrix_chain_cost_evaluator_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop, well past the slowest legal run
  initial begin
    #5_000_000;
    $display("** matrix_chain_cost_evaluator_core: FAILED **");
    $finish;
  end

  // Stimulus and scoreboard state
  symbol_t       request_q [$];
  chain_result_t expected_results [$];
  int            queued_count = 0;
  int            fail_count = 0;
  int            src_idle_pct = 0;
  int            sink_stall_pct = 0;
  logic          in_taken = 1'b0;
  symbol_t       drv_sym;

  // Shadow of the evaluator: size table, operand stack, running cost
  logic [63:0] tab_rows [LETTER_COUNT] = '{default: '0};
  logic [63:0] tab_cols [LETTER_COUNT] = '{default: '0};
  logic [63:0] stk_rows [STACK_DEPTH];
  logic [63:0] stk_cols [STACK_DEPTH];
  int          stk_n = 0;
  logic [63:0] cost_acc = '0;
  logic        chain_err = 1'b0;

  task automatic push_dims(logic [63:0] r, logic [63:0] c);
    if (stk_n >= STACK_DEPTH) begin
      chain_err = 1'b1;
    end else begin
      stk_rows[stk_n] = r;
      stk_cols[stk_n] = c;
      stk_n++;
    end
  endtask

  // Applies one accepted request; queues the result the last symbol produces
  task automatic eval_symbol(req_t kind, logic [4:0] ltr, logic [63:0] r, logic [63:0] c,
                             logic last);
    logic [63:0] lr, lc, rr, rc;
    if (kind == REQ_LOAD) begin
      if (ltr < LETTER_COUNT) begin
        tab_rows[ltr] = r;
        tab_cols[ltr] = c;
      end
      return;  // loads never end an expression
    end
    if (!chain_err) begin
      if (kind == REQ_CLOSE) begin
        if (stk_n < 2) begin
          chain_err = 1'b1;
        end else begin
          rr = stk_rows[stk_n-1];
          rc = stk_cols[stk_n-1];
          lr = stk_rows[stk_n-2];
          lc = stk_cols[stk_n-2];
          stk_n -= 2;
          if (lc != rr) begin
            chain_err = 1'b1;
          end else begin
            cost_acc += lr * lc * rc;
            push_dims(lr, rc);
          end
        end
      end else if (kind == REQ_LETTER) begin
        if (ltr < LETTER_COUNT) push_dims(tab_rows[ltr], tab_cols[ltr]);
        else push_dims('0, '0);
      end
    end
    if (last) begin
      expected_results.push_back('{chain_err ? 64'd0 : cost_acc, chain_err});
      stk_n = 0;
      cost_acc = '0;
      chain_err = 1'b0;
    end
  endtask

  // Driver: a new request once the previous one has been taken
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (request_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        drv_sym = request_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= drv_sym.kind;
        s_axis_tdata  <= {{(S_DATA_W-133){1'b0}}, drv_sym.cols, drv_sym.rows, drv_sym.letter};
        s_axis_tlast  <= drv_sym.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= !rst && ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Monitor: predict on accepted requests, compare accepted results
  always @(posedge clk) begin : monitor
    chain_result_t want;
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        eval_symbol(req_t'(s_axis_tuser), s_axis_tdata[4:0], s_axis_tdata[68:5],
                    s_axis_tdata[132:69], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with none pending: cost %0h error %0b", m_axis_tdata, m_axis_tuser);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata !== want.cost) begin
            $error("cost: expected %0h, got %0h", want.cost, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tuser !== want.error) begin
            $error("error: expected %0b, got %0b", want.error, m_axis_tuser);
            fail_count++;
          end
        end
      end
    end
  end

  function automatic logic [63:0] rand_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return {$urandom, $urandom};
      default: return 64'($urandom_range(1, 1000));
    endcase
  endfunction

  task automatic queue_request(req_t kind, int ltr, logic [63:0] r, logic [63:0] c,
                               logic last);
    symbol_t s;
    s.kind   = kind;
    s.letter = 5'(ltr);
    s.rows   = r;
    s.cols   = c;
    s.last   = last;
    request_q.push_back(s);
    queued_count++;
  endtask

  // One expression: mostly a consistent chain, sometimes deep pushes or junk
  task automatic make_expression();
    int pick, n, depth, base, noise, bad_pos, ltr;
    logic [63:0] dim [0:8];
    bit force_close;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      // push past the stack depth (or to just short of it)
      n = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2);
      for (int i = 0; i < n; i++)
        queue_request(REQ_LETTER, $urandom_range(0, 31), rand_dim(), rand_dim(), 1'b0);
      if ($urandom_range(0, 1)) queue_request(REQ_CLOSE, 0, '0, '0, 1'b0);
    end else if (pick < 13) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++)
        queue_request(req_t'($urandom_range(0, 3)), $urandom_range(0, 31), rand_dim(),
                      rand_dim(), 1'b0);
    end else begin
      n = $urandom_range(1, 8);
      base = $urandom_range(0, LETTER_COUNT - 1);
      noise = $urandom_range(0, 99);
      bad_pos = $urandom_range(0, n - 1);
      for (int i = 0; i <= n; i++) dim[i] = rand_dim();
      // tlast set at random on loads: it must have no effect
      for (int i = 0; i < n; i++)
        queue_request(REQ_LOAD, (base + i) % LETTER_COUNT, dim[i], dim[i+1],
                      $urandom_range(0, 1));
      depth = 0;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 2) == 0)
          queue_request(REQ_OPEN, $urandom_range(0, 31), rand_dim(), rand_dim(), 1'b0);
        if (noise >= 8 && noise < 14 && i == bad_pos)
          queue_request(REQ_LOAD, $urandom_range(0, 31), rand_dim(), rand_dim(), 1'b0);
        ltr = (noise < 8 && i == bad_pos) ? $urandom_range(0, 31) : (base + i) % LETTER_COUNT;
        queue_request(REQ_LETTER, ltr, '0, '0, 1'b0);
        depth++;
        // leave operands on the stack now and then
        force_close = (i == n - 1) && !(noise >= 19 && noise < 23);
        while (depth >= 2 && (force_close || $urandom_range(0, 1))) begin
          queue_request(REQ_CLOSE, $urandom_range(0, 31), '0, '0, 1'b0);
          depth--;
        end
      end
      if (noise >= 14 && noise < 19) queue_request(REQ_CLOSE, 0, '0, '0, 1'b0);
      if ($urandom_range(0, 7) == 0) queue_request(REQ_OPEN, 0, '0, '0, 1'b0);
    end
    request_q[request_q.size()-1].last = 1'b1;
  endtask

  // Sender holds back until every queued request is in and every result out
  task automatic settle();
    while (request_q.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  int idle_src  [4] = '{0, 71, 0, 8};
  int idle_sink [4] = '{0, 0, 71, 8};
  int target = 0;

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: extreme sizes, every symbol, error paths
    queue_request(REQ_LOAD, LTR_A, DIM_ONES, '0, 1'b1);        // tlast on a load: no result
    queue_request(REQ_LOAD, LTR_BAD, DIM_ONES, DIM_ONES, 1'b0); // out of range, dropped
    queue_request(REQ_LOAD, LTR_B, '0, DIM_ONES, 1'b0);
    queue_request(REQ_OPEN, 0, '0, '0, 1'b0);
    queue_request(REQ_LETTER, LTR_A, '0, '0, 1'b0);
    queue_request(REQ_LETTER, LTR_B, '0, '0, 1'b0);
    queue_request(REQ_CLOSE, 0, '0, '0, 1'b1);
    queue_request(REQ_LOAD, LTR_C, DIM_ONES, 64'd3, 1'b0);
    queue_request(REQ_LOAD, LTR_D, 64'd3, 64'd5, 1'b0);
    queue_request(REQ_OPEN, 0, '0, '0, 1'b0);
    queue_request(REQ_LETTER, LTR_C, '0, '0, 1'b0);
    queue_request(REQ_LETTER, LTR_D, '0, '0, 1'b0);
    queue_request(REQ_CLOSE, 0, '0, '0, 1'b1);                // cost wraps
    queue_request(REQ_LETTER, LTR_BAD, '0, '0, 1'b0);         // pushes 0 by 0
    queue_request(REQ_LETTER, LTR_E, '0, '0, 1'b0);           // never loaded
    queue_request(REQ_CLOSE, 0, '0, '0, 1'b1);
    queue_request(REQ_CLOSE, 0, '0, '0, 1'b1);                // underflow
    queue_request(REQ_LETTER, LTR_A, '0, '0, 1'b0);
    queue_request(REQ_LETTER, LTR_C, '0, '0, 1'b0);
    queue_request(REQ_CLOSE, 0, '0, '0, 1'b0);                // size mismatch
    queue_request(REQ_LETTER, LTR_D, '0, '0, 1'b0);           // ignored after error
    queue_request(REQ_OPEN, 0, '0, '0, 1'b1);
    queue_request(REQ_LETTER, LTR_D, '0, '0, 1'b0);
    queue_request(REQ_LETTER, LTR_D, '0, '0, 1'b1);           // leftover operands
    queue_request(REQ_OPEN, 0, '0, '0, 1'b1);                 // empty expression
    settle();

    // Random phases with different idle patterns on each side
    for (int p = 0; p < 4; p++) begin
      src_idle_pct = idle_src[p];
      sink_stall_pct = idle_sink[p];
      target += 425;
      while (queued_count < target) make_expression();
      settle();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("** matrix_chain_cost_evaluator_core: PASSED **");
    end else begin
      $display("** matrix_chain_cost_evaluator_core: FAILED **");
    end
    $finish;
  end

endmodule
